/* rtl/positional_list_store_macros.svh */
// assertion macros shared by the positional list store rtl
// relies on clk and rst being visible in the module that uses them
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pls_pkg.sv */
// shared types and constants for the positional list store
// no dependencies
package pls_pkg;

  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_WAIT,
    S_FIND_RD,
    S_FIND_CMP,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mem_rd;
    logic shift_wr;
    logic put;
    logic count_dec;
    logic step;
    logic hit;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    opcode_t op;
    logic    req_ok;
    logic    more;
    logic    match;
  } status_t;

endpackage

/* rtl/pls_if.sv */
// request and response channel interfaces for the positional list store
// depends on pls_pkg for field widths
interface pls_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [pls_pkg::POS_W-1:0]       position;
  logic signed [pls_pkg::VAL_W-1:0] item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

interface pls_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic signed [pls_pkg::VAL_W-1:0] read_value;
  logic [pls_pkg::POS_W-1:0]       found_position;
  logic [pls_pkg::POS_W-1:0]       entry_count;

  modport source (output valid, ok, read_value, found_position, entry_count, input ready);
  modport sink   (input valid, ok, read_value, found_position, entry_count, output ready);
endinterface

/* rtl/pls_ctrl.sv */
// controller state machine: sequences shift, read and search sweeps
// depends on pls_pkg and positional_list_store_macros.svh
`include "positional_list_store_macros.svh"

module pls_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pls_pkg::status_t status,
  output pls_pkg::cmd_t    cmd
);
  import pls_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic [3:0] upd_bits;

  // state register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.op)
          OP_INSERT, OP_DELETE: state_next = status.req_ok ? S_SHIFT_RD : S_FINISH;
          OP_READ: begin
            if (status.req_ok) begin
              cmd.mem_rd = 1'b1;
              state_next = S_READ_WAIT;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_FIND: state_next = S_FIND_RD;
          default: state_next = S_FINISH;
        endcase
      end
      // move one entry per pass, then place or drop
      S_SHIFT_RD: begin
        if (status.more) begin
          cmd.mem_rd = 1'b1;
          state_next = S_SHIFT_WR;
        end else begin
          if (status.op == OP_INSERT) begin
            cmd.put = 1'b1;
          end else begin
            cmd.count_dec = 1'b1;
          end
          state_next = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.step     = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_READ_WAIT: state_next = S_FINISH;
      // linear search over stored entries
      S_FIND_RD: begin
        if (status.more) begin
          cmd.mem_rd = 1'b1;
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FIND_CMP: begin
        if (status.match) begin
          cmd.hit    = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_FIND_RD;
        end
      end
      // post the result word once the output register is free
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign upd_bits = {cmd.shift_wr, cmd.put, cmd.count_dec, cmd.mem_rd};

  `PLS_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state == S_DISPATCH, "accepted word not dispatched")
  `PLS_ASSERT(a_single_update, $onehot0(upd_bits), "conflicting datapath updates")
  `PLS_ASSERT_NEXT(a_result_posted, cmd.finish, out_valid, "finished result not posted")

endmodule

/* rtl/pls_datapath.sv */
// datapath: entry memory, count, sweep index, request and result registers
// depends on pls_pkg and positional_list_store_macros.svh
`include "positional_list_store_macros.svh"

module pls_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pls_pkg::cmd_t                    cmd,
  output pls_pkg::status_t                 status,
  input  logic [1:0]                       opcode,
  input  logic [pls_pkg::POS_W-1:0]        position,
  input  logic signed [pls_pkg::VAL_W-1:0] item_value,
  output logic                             ok,
  output logic signed [pls_pkg::VAL_W-1:0] read_value,
  output logic [pls_pkg::POS_W-1:0]        found_position,
  output logic [pls_pkg::POS_W-1:0]        entry_count
);
  import pls_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [VAL_W-1:0] mem [CAPACITY];

  opcode_t          op_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    count;
  logic             req_ok;
  logic             hit;
  logic [VAL_W-1:0] rd_data;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] in_pos_x;
  logic [XW-1:0] in_pos_m1_x;
  logic [XW-1:0] rd_addr_x;
  logic [XW-1:0] fp_x;
  logic          req_ok_next;
  logic [CW-1:0] idx_init;
  logic          mem_wr;
  logic [VAL_W-1:0] wr_data;
  logic          sweep_more;

  assign cnt_x       = XW'(count);
  assign idx_x       = XW'(idx);
  assign pos_x       = XW'(pos_q);
  assign in_pos_x    = XW'(position);
  assign in_pos_m1_x = in_pos_x - XW'(1);
  assign fp_x        = idx_x + XW'(1);

  // request check and sweep start point
  always_comb begin
    case (opcode_t'(opcode))
      OP_INSERT: begin
        req_ok_next = (in_pos_x != '0) && (in_pos_x <= cnt_x + XW'(1))
                      && (cnt_x < XW'(CAPACITY));
        idx_init    = count;
      end
      OP_DELETE, OP_READ: begin
        req_ok_next = (in_pos_x != '0) && (in_pos_x <= cnt_x);
        idx_init    = in_pos_m1_x[CW-1:0];
      end
      OP_FIND: begin
        req_ok_next = 1'b1;
        idx_init    = '0;
      end
      default: begin
        req_ok_next = 1'b0;
        idx_init    = '0;
      end
    endcase
  end

  // loop condition and read address per operation
  always_comb begin
    case (op_q)
      OP_INSERT: begin
        sweep_more = (idx_x >= pos_x);
        rd_addr_x  = idx_x - XW'(1);
      end
      OP_DELETE: begin
        sweep_more = (idx_x + XW'(1) < cnt_x);
        rd_addr_x  = idx_x + XW'(1);
      end
      OP_FIND: begin
        sweep_more = (idx_x < cnt_x);
        rd_addr_x  = idx_x;
      end
      default: begin
        sweep_more = 1'b0;
        rd_addr_x  = idx_x;
      end
    endcase
  end

  assign status.op     = op_q;
  assign status.req_ok = req_ok;
  assign status.more   = sweep_more;
  assign status.match  = (rd_data == val_q);

  assign mem_wr  = cmd.shift_wr || cmd.put;
  assign wr_data = cmd.put ? val_q : rd_data;

  // request capture and sweep index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode_t'(opcode);
      pos_q <= position;
      val_q <= item_value;
      idx   <= idx_init;
    end else if (cmd.step) begin
      if (op_q == OP_INSERT) begin
        idx <= idx - CW'(1);
      end else begin
        idx <= idx + CW'(1);
      end
    end
  end

  // count and status flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      req_ok <= 1'b0;
      hit    <= 1'b0;
    end else begin
      if (cmd.put) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        req_ok <= req_ok_next;
        hit    <= 1'b0;
      end else if (cmd.hit) begin
        hit <= 1'b1;
      end
    end
  end

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[idx[AW-1:0]] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_addr_x[AW-1:0]];
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ok             <= (op_q == OP_FIND) ? hit : req_ok;
      read_value     <= (op_q == OP_READ && req_ok) ? rd_data : '0;
      found_position <= hit ? fp_x[POS_W-1:0] : '0;
      entry_count    <= cnt_x[POS_W-1:0];
    end
  end

  `PLS_ASSERT(a_count_cap, cnt_x <= XW'(CAPACITY), "count exceeds capacity")
  `PLS_ASSERT_NEXT(a_put_grows, cmd.put, count == $past(count) + CW'(1), "insert did not grow count")
  `PLS_ASSERT(a_wr_in_range, mem_wr |-> (idx_x < XW'(CAPACITY)), "memory write out of range")

endmodule

/* rtl/positional_list_store.sv */
// top level of the positional list store: ordered list with insert/delete at position
// depends on pls_pkg, pls_if, pls_ctrl and pls_datapath
//
// Keeps up to CAPACITY signed 32-bit words in a single-port-style memory
// (one write, one registered read per cycle) and serves one request word at
// a time; each request gives exactly one response word. Insert and delete
// move the entries above the position one at a time, each one read and then
// written back (shift read, shift write); a read goes through dispatch, a
// memory read and a read wait; a find reads and compares the stored entries
// in order and stops at the first match; a rejected insert, delete or read
// goes from dispatch straight to finish. A response word that is not taken
// holds the next request in the finish state until it is. The memory is not
// cleared after reset: only entries below the count are ever read. A new
// request is taken as soon as the previous one is finished, even while its
// response word still waits in the output register. Positions are 1-based.
module positional_list_store #(
  parameter int CAPACITY = 64
) (
  input logic      clk,
  input logic      rst,
  pls_req_if.sink  req,
  pls_rsp_if.source rsp
);
  import pls_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and result
  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (req.opcode),
    .position       (req.position),
    .item_value     (req.item_value),
    .ok             (rsp.ok),
    .read_value     (rsp.read_value),
    .found_position (rsp.found_position),
    .entry_count    (rsp.entry_count)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench for positional_list_store: directed probe table, then random request words
// checked against an in-bench list predictor; depends on pls_pkg, pls_if and the rtl top
module testbench;
  import pls_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_LEN    = 125;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_AT     = 600;
  localparam int SETTLE       = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        entry_count;
  } outcome_t;

  typedef struct packed {
    opcode_t                 op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic                    typed;
    outcome_t                want;
  } probe_t;

  typedef enum int {FILL, CHURN, DRAIN} mix_t;

  // directed probes: rows with typed set carry their own expected word
  localparam probe_t PROBES [24] = '{
    '{OP_READ,   7'd1,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{OP_DELETE, 7'd1,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{OP_FIND,   7'd0,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{OP_INSERT, 7'd0,   32'sd5,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{OP_INSERT, 7'd2,   32'sd5,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{OP_INSERT, 7'd1,   32'sh7fff_ffff,   1'b1, '{1'b1, 32'sd0, 7'd0, 7'd1}},
    '{OP_INSERT, 7'd1,   32'sh8000_0000,   1'b1, '{1'b1, 32'sd0, 7'd0, 7'd2}},
    '{OP_INSERT, 7'd3,   -32'sd1,          1'b1, '{1'b1, 32'sd0, 7'd0, 7'd3}},
    '{OP_INSERT, 7'd2,   32'sd0,           1'b0, '0},
    '{OP_READ,   7'd1,   -32'sd1,          1'b0, '0},
    '{OP_READ,   7'd4,   32'sd0,           1'b0, '0},
    '{OP_READ,   7'd5,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
    '{OP_READ,   7'd127, 32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
    '{OP_FIND,   7'd127, 32'sh7fff_ffff,   1'b0, '0},
    '{OP_FIND,   7'd1,   32'sd12345,       1'b0, '0},
    '{OP_INSERT, 7'd5,   32'sd0,           1'b0, '0},
    '{OP_FIND,   7'd0,   32'sd0,           1'b0, '0},
    '{OP_DELETE, 7'd6,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd5}},
    '{OP_DELETE, 7'd0,   32'sd0,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd5}},
    '{OP_DELETE, 7'd5,   32'sd0,           1'b0, '0},
    '{OP_DELETE, 7'd1,   32'sd0,           1'b0, '0},
    '{OP_READ,   7'd1,   32'sd0,           1'b0, '0},
    '{OP_FIND,   7'd64,  32'sh8000_0000,   1'b0, '0},
    '{OP_INSERT, 7'd127, 32'sd9,           1'b1, '{1'b0, 32'sd0, 7'd0, 7'd3}}
  };

  logic clk = 1'b0;
  logic rst;

  pls_req_if req_ch ();
  pls_rsp_if rsp_ch ();

  positional_list_store #(.CAPACITY(LIST_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state and the words still owed by the block
  logic signed [VAL_W-1:0] stored_list [$];
  outcome_t                pending [$];

  int  failures       = 0;
  int  requests_sent  = 0;
  int  responses_seen = 0;
  int  next_gap       = 0;
  bit  drain_first    = 1'b0;
  bit  req_gaps_off   = 1'b0;
  bit  rsp_gaps_off   = 1'b0;
  int  cycle_count    = 0;

  always #10 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("positional_list_store: mismatch");
      $finish;
    end
  end

  // apply one request to the predicted list and return the word it should give
  function automatic outcome_t apply_request(input opcode_t op, input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] val);
    outcome_t r;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (pos >= 1 && pos <= stored_list.size() + 1 && stored_list.size() < LIST_DEPTH) begin
          stored_list.insert(pos - 1, val);
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= stored_list.size()) begin
          stored_list.delete(pos - 1);
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos >= 1 && pos <= stored_list.size()) begin
          r.read_value = stored_list[pos - 1];
          r.ok = 1'b1;
        end
      end
      default: begin
        // first match wins
        for (int i = 0; i < stored_list.size(); i++) begin
          if (stored_list[i] == val) begin
            r.found_position = POS_W'(i + 1);
            r.ok = 1'b1;
            break;
          end
        end
      end
    endcase
    r.entry_count = POS_W'(stored_list.size());
    return r;
  endfunction

  // offer one request word, record its expected response once accepted
  task automatic offer(input opcode_t op, input logic [POS_W-1:0] pos,
                       input logic signed [VAL_W-1:0] val, input logic typed,
                       input outcome_t want);
    outcome_t predicted;
    repeat (next_gap) @(posedge clk);
    while (drain_first && pending.size() != 0) @(posedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.position   <= pos;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(op, pos, val);
    pending.push_back(typed ? want : predicted);
    requests_sent++;
    // idle pattern for the next word; valid stays up when there is no gap and no drain is due
    if ($urandom_range(0, 99) < 4) req_gaps_off = !req_gaps_off;
    next_gap    = req_gaps_off ? 0 : $urandom_range(0, 17);
    drain_first = (requests_sent == DRAIN_AT);
    if (next_gap != 0 || drain_first) req_ch.valid <= 1'b0;
  endtask

  // request side: probe table, then random phases that fill, churn and drain the list
  initial begin
    mix_t                    mix;
    opcode_t                 op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      roll;
    int                      n_now;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_INSERT;
    req_ch.position   <= '0;
    req_ch.item_value <= '0;
    do @(posedge clk); while (rst);

    foreach (PROBES[i])
      offer(PROBES[i].op, PROBES[i].pos, PROBES[i].val, PROBES[i].typed, PROBES[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0: mix = FILL;
        2: mix = DRAIN;
        default: mix = CHURN;
      endcase
      n_now = stored_list.size();

      // operation mix follows the phase
      roll = $urandom_range(0, 99);
      case (mix)
        FILL:  op = roll < 85 ? OP_INSERT : roll < 90 ? OP_DELETE : roll < 95 ? OP_READ : OP_FIND;
        DRAIN: op = roll < 80 ? OP_DELETE : roll < 85 ? OP_INSERT : roll < 92 ? OP_READ : OP_FIND;
        default: op = opcode_t'($urandom_range(0, 3));
      endcase

      // mostly legal positions with weight on the ends, some raw noise
      roll = $urandom_range(0, 99);
      if (roll < 8)
        pos = POS_W'($urandom_range(0, 127));
      else if (op == OP_INSERT)
        pos = POS_W'(roll < 20 ? n_now + 1 : roll < 30 ? 1 : $urandom_range(1, n_now + 1));
      else
        pos = POS_W'(roll < 20 ? n_now : roll < 30 ? 1
                     : $urandom_range(1, n_now > 0 ? n_now : 1));

      // small values repeat so find sees duplicates; find often targets a stored value
      roll = $urandom_range(0, 99);
      if (op == OP_FIND && n_now > 0 && roll < 60)
        val = stored_list[$urandom_range(0, n_now - 1)];
      else if (roll < 35)
        val = int'($urandom_range(0, 6)) - 3;
      else if (roll < 45)
        val = roll[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
      else
        val = $urandom;

      offer(op, pos, val, 1'b0, '0);
    end
    if (next_gap == 0 && !drain_first) req_ch.valid <= 1'b0;

    // let the last words come back, then allow for a full sweep of the list
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && pending.size() == 0) begin
      $display("positional_list_store: match");
    end else begin
      $display("positional_list_store: mismatch");
    end
    $finish;
  end

  // response side: random stalls, one long hold-off, field by field compare
  initial begin
    int       stall;
    outcome_t want;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      repeat (stall) @(posedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (pending.size() == 0) begin
        $error("response word with no request outstanding");
        failures++;
      end else begin
        want = pending.pop_front();
        if (rsp_ch.ok !== want.ok) begin
          $error("ok: expected %0d actual %0d", want.ok, rsp_ch.ok);
          failures++;
        end
        if (rsp_ch.read_value !== want.read_value) begin
          $error("read_value: expected %0d actual %0d", want.read_value, rsp_ch.read_value);
          failures++;
        end
        if (rsp_ch.found_position !== want.found_position) begin
          $error("found_position: expected %0d actual %0d",
                 want.found_position, rsp_ch.found_position);
          failures++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d actual %0d", want.entry_count, rsp_ch.entry_count);
          failures++;
        end
      end
      responses_seen++;
      if ($urandom_range(0, 99) < 4) rsp_gaps_off = !rsp_gaps_off;
      if (responses_seen == HOLD_AT)
        stall = HOLD_CYCLES;
      else
        stall = rsp_gaps_off ? 0 : $urandom_range(0, 17);
      if (stall != 0) rsp_ch.ready <= 1'b0;
    end
  end

endmodule
